FILE: design/salc_pkg.sv
// Package of the set-associative cache tag controller: sizes, line operation
// and stored way entry types. No dependencies.
`default_nettype none
package salc_pkg;
  localparam int unsigned CACHE_BYTES = 131072;
  localparam int unsigned WAY_SLOTS   = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CACHE_LOG   = $clog2(CACHE_BYTES);
  localparam int unsigned WAY_W       = 4;
  localparam int unsigned RANK_W      = 4;
  localparam int unsigned SET_W       = CACHE_LOG - 2;
  localparam int unsigned ROWS        = CACHE_BYTES / 4;
  localparam int unsigned TAG_W       = ADDR_W - CACHE_LOG + WAY_W;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);

  // write policy codes
  localparam logic [1:0] POL_WB       = 2'd0;
  localparam logic [1:0] POL_WT_NOALC = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_BURST  = 2'd0;
  localparam logic [1:0] CFG_WAYS   = 2'd1;
  localparam logic [1:0] CFG_POLICY = 2'd2;

  // one line touched by an access
  typedef struct packed {
    logic             is_write;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic [1:0]       words;
  } line_op_t;

  // one way of a set
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] rank;
  } way_t;

  typedef way_t [WAY_SLOTS-1:0] set_row_t;

  // result of one touched line
  typedef struct packed {
    logic        last;
    logic [1:0]  memory_word_writes;
    logic [14:0] line_index;
    logic [18:0] victim_tag;
    logic        dirty_writeback;
    logic        allocated;
    logic [3:0]  way_used;
    logic        hit;
  } result_t;
endpackage
`default_nettype wire

FILE: design/salc_queue.sv
// Short queue of line operations between front and back.
// Depends on salc_pkg.
`default_nettype none
module salc_queue import salc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire line_op_t push_op_i,
  input  wire logic     pop_i,
  output line_op_t      head_o,
  output logic          full_o,
  output logic          empty_o
);
  line_op_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = wr_q + 1'b1;
    if (pop_i) rd_d = rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_op_i;
  end
endmodule
`default_nettype wire

FILE: design/salc_front.sv
// Front end: splits an access into one or two line operations (none for
// a zero byte count) and queues them. Depends on salc_pkg.
`default_nettype none
module salc_front import salc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [1:0]        burst_log_i,
  input  wire logic [2:0]        ways_log_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [2:0]        byte_count_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output line_op_t               push_op_o
);
  logic        hold_q, sec_q, two_q;
  line_op_t    op_a_q, op_b_q;
  logic [2:0]  bb, wl;
  logic [4:0]  lb;
  logic [ADDR_W-1:0] end_addr, set_mask;
  logic        two;
  logic [3:0]  wsum;
  logic [1:0]  words;
  logic        accept;
  line_op_t    op_a, op_b;

  // address split for the current geometry
  always_comb begin
    bb       = 3'd2 + {1'b0, burst_log_i};
    wl       = (ways_log_i > 3'(WAY_W)) ? 3'(WAY_W) : ways_log_i;
    lb       = 5'(CACHE_LOG) - {2'b0, bb} - {2'b0, wl};
    set_mask = (ADDR_W'(1) << lb) - 1'b1;
    end_addr = address_i + ADDR_W'(byte_count_i) - 1'b1;
    two      = (address_i >> bb) != (end_addr >> bb);
    wsum     = {2'b0, address_i[1:0]} + {1'b0, byte_count_i} - 4'd1;
    words    = wsum[3:2] + 2'd1;
    op_a.is_write = req_type_i;
    op_a.set      = SET_W'((address_i >> bb) & set_mask);
    op_a.tag      = TAG_W'(address_i >> (bb + lb));
    op_a.last     = !two;
    op_a.words    = words;
    op_b.is_write = req_type_i;
    op_b.set      = SET_W'((end_addr >> bb) & set_mask);
    op_b.tag      = TAG_W'(end_addr >> (bb + lb));
    op_b.last     = 1'b1;
    op_b.words    = words;
  end

  assign in_ready_o = en_i && !hold_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = hold_q && !q_full_i;
  assign push_op_o  = sec_q ? op_b_q : op_a_q;

  // hold the access until all its lines are queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      sec_q  <= 1'b0;
      two_q  <= 1'b0;
    end else if (accept) begin
      hold_q <= (byte_count_i != 3'd0);
      sec_q  <= 1'b0;
      two_q  <= two;
    end else if (push_o) begin
      if (!sec_q && two_q) begin
        sec_q <= 1'b1;
      end else begin
        hold_q <= 1'b0;
        sec_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_a_q <= op_a;
      op_b_q <= op_b;
    end
  end
endmodule
`default_nettype wire

FILE: design/salc_back.sv
// Back end: set memory, clearing pass, hit and victim search, LRU rank
// update and the result register. Depends on salc_pkg.
`default_nettype none
module salc_back import salc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [2:0] ways_log_i,
  input  wire logic [1:0] policy_i,
  input  wire line_op_t   head_i,
  input  wire logic       q_empty_i,
  output logic            pop_o,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output result_t         out_o
);
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SET_W-1:0] clr_q;
  set_row_t         mem [ROWS];
  set_row_t         rd_row_q, new_row, clr_row;
  line_op_t         op_q;
  logic             out_valid_q;
  result_t          out_q, res;
  logic [2:0]       wl;
  logic [4:0]       ways;
  logic [RANK_W-1:0] top_rank, use_rank;
  logic             hit, alloc, vfound;
  logic [WAY_W-1:0] hw, vw, uw;
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  set_row_t         mem_wd;

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign pop_o = (state_q == S_IDLE) && !q_empty_i && (!out_valid_q || out_ready_i);

  // reset image of a set
  always_comb begin
    for (int w = 0; w < WAY_SLOTS; w++) begin
      clr_row[w]      = '0;
      clr_row[w].rank = RANK_W'(w);
    end
  end

  // hit search, victim search and rank update
  always_comb begin
    wl       = (ways_log_i > 3'(WAY_W)) ? 3'(WAY_W) : ways_log_i;
    ways     = 5'd1 << wl;
    top_rank = RANK_W'(ways - 5'd1);
    hit = 1'b0;
    hw  = '0;
    for (int w = 0; w < WAY_SLOTS; w++) begin
      if (5'(w) < ways && !hit && rd_row_q[w].valid && rd_row_q[w].tag == op_q.tag) begin
        hit = 1'b1;
        hw  = WAY_W'(w);
      end
    end
    alloc  = !hit && (!op_q.is_write || policy_i != POL_WT_NOALC);
    vfound = 1'b0;
    vw     = '0;
    for (int w = 0; w < WAY_SLOTS; w++) begin
      if (5'(w) < ways && !vfound && rd_row_q[w].rank == top_rank) begin
        vfound = 1'b1;
        vw     = WAY_W'(w);
      end
    end
    uw       = hit ? hw : vw;
    use_rank = rd_row_q[uw].rank;
    new_row  = rd_row_q;
    if (hit || alloc) begin
      for (int w = 0; w < WAY_SLOTS; w++) begin
        if (5'(w) < ways && WAY_W'(w) != uw && rd_row_q[w].rank < use_rank)
          new_row[w].rank = rd_row_q[w].rank + 1'b1;
      end
      new_row[uw].rank = '0;
    end
    if (hit && op_q.is_write && policy_i == POL_WB) new_row[hw].dirty = 1'b1;
    if (alloc) begin
      new_row[vw].tag   = op_q.tag;
      new_row[vw].valid = 1'b1;
      new_row[vw].dirty = op_q.is_write && policy_i == POL_WB;
    end
    res.hit             = hit;
    res.way_used        = (hit || alloc) ? uw : '0;
    res.allocated       = alloc;
    res.dirty_writeback = alloc && rd_row_q[vw].dirty;
    res.victim_tag      = (alloc && rd_row_q[vw].valid) ? 19'(rd_row_q[vw].tag) : '0;
    res.line_index      = 15'(op_q.set);
    res.memory_word_writes = (op_q.last && op_q.is_write && policy_i != POL_WB) ?
                             op_q.words : 2'd0;
    res.last            = op_q.last;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == SET_W'(ROWS - 1)) state_d = S_IDLE;
      S_IDLE:  if (pop_o) state_d = S_LOOK;
      S_LOOK:  state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_LOOK) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) op_q <= head_i;
    if (state_q == S_LOOK) out_q <= res;
  end

  // set memory: one write, one registered read
  assign mem_we = (state_q == S_CLEAR) || (state_q == S_LOOK);
  assign mem_wa = (state_q == S_CLEAR) ? clr_q : op_q.set;
  assign mem_wd = (state_q == S_CLEAR) ? clr_row : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_row_q <= mem[head_i.set];
  end

  a_no_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q) else $error("result during clearing pass");
  a_hit_xor_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.allocated)) else $error("hit and allocation");
  a_look_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> !out_valid_q) else $error("result register overwritten");
  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_LOOK) else $error("pop without lookup");
endmodule
`default_nettype wire

FILE: design/set_assoc_cache_lru_controller.sv
// Top level of the set-associative cache tag controller with rank LRU.
// Usage:
//   s_axis carries accesses: tuser = req_type (0 read, 1 write), tdata =
//   address then byte_count. m_axis returns one transaction per touched cache
//   line (one or two, start line first, none for byte_count 0), tlast on last.
//   Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i, only while idle.
// Line sequence:
//   The back end pops each line in S_IDLE and reads its set from the set
//   memory, then in S_LOOK does the lookup, rank update and set write-back.
//   It pops only when the result register is empty or being taken.
// Reset:
//   A clearing pass writes every one of the 32768 set rows;
//   s_axis_tready stays low until it is done.
// Stall:
//   A result waits in the output register; the front end and the short
//   line queue keep accepting until the queue fills.
// Depends on salc_pkg, salc_front, salc_queue, salc_back.
`default_nettype none
module set_assoc_cache_lru_controller import salc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // address[31:0], byte_count[34:32], zero
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // hit, way_used, allocated,
                                          // dirty_writeback, victim_tag,
                                          // line_index, memory_word_writes, zero
  output logic             m_axis_tlast
);
  logic [1:0] burst_q, policy_q;
  logic [2:0] ways_q;
  logic       clearing, q_full, q_empty, push, pop, out_valid;
  line_op_t   push_op, head;
  result_t    res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q  <= '0;
      ways_q   <= '0;
      policy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BURST:  burst_q  <= cfg_data_i[1:0];
        CFG_WAYS:   ways_q   <= cfg_data_i;
        CFG_POLICY: policy_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk_i, .rst_ni,
    .en_i        (!clearing),
    .burst_log_i (burst_q),
    .ways_log_i  (ways_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .address_i   (s_axis_tdata[31:0]),
    .byte_count_i(s_axis_tdata[34:32]),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  salc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i   (push),
    .push_op_i(push_op),
    .pop_i    (pop),
    .head_o   (head),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  salc_back u_back (
    .clk_i, .rst_ni,
    .ways_log_i (ways_q),
    .policy_i   (policy_q),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.last;
  assign m_axis_tdata  = {5'd0, res.memory_word_writes, res.line_index, res.victim_tag,
                          res.dirty_writeback, res.allocated, res.way_used, res.hit};
endmodule
`default_nettype wire

FILE: verif/tb_set_assoc_cache_lru_controller.sv
// Self-checking testbench of the set-associative cache tag controller.
// Drives accesses on s_axis, predicts per-line results in a local cache model
// and compares m_axis transactions in order. Depends on salc_pkg and the RTL.
`default_nettype none
module tb_set_assoc_cache_lru_controller;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS_MAX   = CACHE_BYTES / 4;
  localparam int unsigned CYCLE_CAP  = 1200000;
  localparam logic        REQ_READ   = 1'b0;
  localparam logic        REQ_WRITE  = 1'b1;

  typedef struct packed {
    logic        req;
    logic [31:0] addr;
    logic [2:0]  cnt;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way;
    logic        alloc;
    logic        dwb;
    logic [18:0] vtag;
    logic [14:0] idx;
    logic [1:0]  words;
    logic        last;
  } line_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [2:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  set_assoc_cache_lru_controller u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cache model state, flattened set*16+way
  logic [18:0] mdl_tag   [SETS_MAX*WAY_SLOTS];
  logic        mdl_valid [SETS_MAX*WAY_SLOTS];
  logic        mdl_dirty [SETS_MAX*WAY_SLOTS];
  logic [3:0]  mdl_rank  [SETS_MAX*WAY_SLOTS];
  logic [1:0]  cur_burst;
  logic [2:0]  cur_ways;
  logic [1:0]  cur_pol;

  access_t   pending_acc[$];
  line_res_t expected_lines[$];
  int        err_count = 0;
  int        cycles = 0;
  bit        in_acc = 1'b0;

  // move a way to rank 0, ageing the younger ones
  function automatic void promote_way(int base, int ways, int w);
    logic [3:0] r;
    r = mdl_rank[base+w];
    for (int j = 0; j < ways; j++)
      if (j != w && mdl_rank[base+j] < r) mdl_rank[base+j] = mdl_rank[base+j] + 4'd1;
    mdl_rank[base+w] = 4'd0;
  endfunction

  function automatic line_res_t lookup_line(logic wr, int set, logic [31:0] tag, int ways);
    line_res_t res;
    int base, vw;
    res = '0;
    base = set * WAY_SLOTS;
    res.idx = set[14:0];
    for (int w = 0; w < ways; w++)
      if (mdl_valid[base+w] && {13'd0, mdl_tag[base+w]} == tag) begin
        res.hit = 1'b1;
        res.way = w[3:0];
        promote_way(base, ways, w);
        if (wr && cur_pol == POL_WB) mdl_dirty[base+w] = 1'b1;
        return res;
      end
    if (wr && cur_pol == POL_WT_NOALC) return res;
    vw = 0;
    for (int w = 0; w < ways; w++)
      if (mdl_rank[base+w] == ways - 1) begin
        vw = w;
        break;
      end
    res.way = vw[3:0];
    res.alloc = 1'b1;
    res.dwb = mdl_dirty[base+vw];
    res.vtag = mdl_valid[base+vw] ? mdl_tag[base+vw] : '0;
    mdl_tag[base+vw] = tag[18:0];
    mdl_valid[base+vw] = 1'b1;
    mdl_dirty[base+vw] = wr && cur_pol == POL_WB;
    promote_way(base, ways, vw);
    return res;
  endfunction

  // expected per-line results of one access
  function automatic void predict_access(access_t a);
    int bb, wl, ways, lb, n, words;
    logic [31:0] ends[2], wd, prev;
    line_res_t res;
    if (a.cnt == 0) return;
    bb = 2 + cur_burst;
    wl = (cur_ways > 4) ? 4 : cur_ways;
    ways = 1 << wl;
    lb = 17 - bb - wl;
    ends[0] = a.addr;
    ends[1] = a.addr + a.cnt - 1;
    n = ((ends[0] >> bb) != (ends[1] >> bb)) ? 2 : 1;
    words = 0;
    prev = '0;
    for (int i = 0; i < a.cnt; i++) begin
      wd = (a.addr + i) >> 2;
      if (i == 0 || wd != prev) words++;
      prev = wd;
    end
    for (int k = 0; k < n; k++) begin
      res = lookup_line(a.req, (ends[k] >> bb) & ((1 << lb) - 1), ends[k] >> (bb + lb), ways);
      if (k == n - 1) begin
        res.last = 1'b1;
        if (a.req && cur_pol != POL_WB) res.words = words[1:0];
      end
      expected_lines.push_back(res);
    end
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_acc <= s_axis_tvalid && s_axis_tready;
  end

  // driver: bursts and gaps, inputs change on falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (in_acc) begin
      predict_access(pending_acc.pop_front());
    end
    if (!s_axis_tvalid || in_acc) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_acc.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_acc[0].req;
        s_axis_tdata <= {5'd0, pending_acc[0].cnt, pending_acc[0].addr};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, periodically fully ready
  always @(negedge clk_i) begin
    if (cycles % 2000 < 400) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 65);
  end

  // monitor: sample at rising edge
  always @(posedge clk_i) begin
    line_res_t got, exp_l;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[5], m_axis_tdata[6],
             m_axis_tdata[25:7], m_axis_tdata[40:26], m_axis_tdata[42:41], m_axis_tlast};
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        err_count <= err_count + 1;
      end else begin
        exp_l = expected_lines.pop_front();
        if (got !== exp_l) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_l, got);
          err_count <= err_count + 1;
        end
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BURST:  cur_burst = val[1:0];
      CFG_WAYS:   cur_ways = val;
      default:    cur_pol = val[1:0];
    endcase
  endtask

  task automatic drain_all();
    while (pending_acc.size() > 0 || s_axis_tvalid || expected_lines.size() > 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // address local to a small window so sets recur and ways fill up
  function automatic access_t rand_access();
    access_t a;
    logic [31:0] tagpart;
    a.req = 1'($urandom_range(0, 1));
    tagpart = $urandom_range(0, 7);
    a.addr = {tagpart[2:0], 29'd0} | ($urandom & 32'h0000_01FF) |
             (($urandom_range(0, 7) == 0) ? $urandom : 32'h0);
    if ($urandom_range(0, 15) == 0) a.addr = 32'hFFFF_FFFF - $urandom_range(0, 3);
    a.cnt = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) :
            3'($urandom_range(1, 4));
    return a;
  endfunction

  initial begin
    for (int i = 0; i < SETS_MAX*WAY_SLOTS; i++) begin
      mdl_tag[i] = '0;
      mdl_valid[i] = 1'b0;
      mdl_dirty[i] = 1'b0;
      mdl_rank[i] = 4'(i % WAY_SLOTS);
    end
    cur_burst = '0;
    cur_ways = '0;
    cur_pol = POL_WB;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, wrap, zero and oversize counts, line splits
    pending_acc.push_back('{REQ_READ, 32'h0, 3'd1});
    pending_acc.push_back('{REQ_WRITE, 32'h0, 3'd4});
    pending_acc.push_back('{REQ_READ, 32'hFFFF_FFFF, 3'd4});
    pending_acc.push_back('{REQ_WRITE, 32'hFFFF_FFFE, 3'd2});
    pending_acc.push_back('{REQ_READ, 32'h0000_0003, 3'd2});
    pending_acc.push_back('{REQ_WRITE, 32'h0000_0000, 3'd0});
    pending_acc.push_back('{REQ_WRITE, 32'h0000_0006, 3'd7});
    pending_acc.push_back('{REQ_READ, 32'hAAAA_AAAA, 3'd5});
    pending_acc.push_back('{REQ_READ, 32'h5555_5555, 3'd3});
    pending_acc.push_back('{REQ_WRITE, 32'h0002_0000, 3'd1});
    pending_acc.push_back('{REQ_READ, 32'h0004_0000, 3'd1});
    drain_all();

    // phases over register settings; extremes first, then mixes
    for (int ph = 0; ph < 14; ph++) begin
      logic [2:0] b, w, p;
      b = (ph == 0) ? 3'd3 : (ph == 1) ? 3'd0 : 3'($urandom_range(0, 3));
      w = (ph == 0) ? 3'd4 : (ph == 1) ? 3'd0 : (ph == 2) ? 3'd7 : 3'($urandom_range(0, 7));
      p = (ph < 3) ? ph[2:0] : (ph == 3) ? 3'd3 : 3'($urandom_range(0, 3));
      write_reg(CFG_BURST, b);
      write_reg(CFG_WAYS, w);
      write_reg(CFG_POLICY, p);
      for (int i = 0; i < 75; i++) pending_acc.push_back(rand_access());
      drain_all();
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
